[rtl/core/bao_pkg.sv]
package bao_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int DEPTH     = MAX_STEPS + 1;
  localparam int AW        = $clog2(DEPTH);
  localparam int W         = 48;

  localparam logic [AW-1:0] STEPS_MAX   = AW'(MAX_STEPS);
  localparam logic [10:0]   STEPS_RESET = 11'd256;

  localparam logic [W-1:0]  ONE     = 48'h0001_0000_0000;
  localparam logic [W-1:0]  MAX48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0]   LN2     = 32'd2977044472;
  localparam logic [W-1:0]  INV_LN2 = 48'd6196328018;

  localparam logic [3:0] EXP_TERMS = 4'd14;
  localparam logic [6:0] DIV_BITS  = 7'd64;
  localparam logic [6:0] Q_BITS    = 7'd32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DT,
    ST_SQ,
    ST_A,
    ST_R,
    ST_EK,
    ST_EM,
    ST_ET,
    ST_EN,
    ST_EFIN,
    ST_Q,
    ST_PWR,
    ST_PMU,
    ST_PMD,
    ST_ROW,
    ST_NRD,
    ST_NM1,
    ST_NM2,
    ST_NM3,
    ST_NM4,
    ST_NM5,
    ST_DONE
  } state_t;

endpackage

[rtl/core/bao_mem.sv]
module bao_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [bao_pkg::AW-1:0]   waddr,
  input  logic [bao_pkg::W-1:0]    wdata,
  input  logic [bao_pkg::AW-1:0]   raddr,
  output logic [bao_pkg::W-1:0]    rdata
);

  logic [bao_pkg::W-1:0] mem [bao_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bao_mulq.sv]
module bao_mulq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [bao_pkg::W-1:0]  a,
  input  logic [bao_pkg::W-1:0]  b,
  output logic                   done,
  output logic [bao_pkg::W-1:0]  res
);

  logic [47:0] hh, p1, p2, p3;
  logic        v1;
  logic [49:0] tt;
  logic [48:0] sum;
  logic [47:0] res_next;

  always_comb begin
    tt  = 50'(p3[47:24]) + 50'(p1) + 50'(p2);
    sum = {1'b0, hh[31:0], 16'b0} + 49'(tt[49:8]);
    if (hh[47:32] != 16'd0 || sum[48]) begin
      res_next = bao_pkg::MAX48;
    end else begin
      res_next = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    hh  <= a[47:24] * b[47:24];
    p1  <= a[47:24] * b[23:0];
    p2  <= a[23:0] * b[47:24];
    p3  <= a[23:0] * b[23:0];
    res <= res_next;
  end

endmodule

[rtl/core/bao_div.sv]
module bao_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  input  logic [47:0] rem_init,
  input  logic [6:0]  count,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] nreg;
  logic [47:0] rreg, dreg;
  logic [6:0]  cnt;
  logic        run;
  logic [48:0] sh;
  logic        ge;

  assign sh        = {rreg, nreg[63]};
  assign ge        = sh >= {1'b0, dreg};
  assign quotient  = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 7'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= dividend;
      rreg <= rem_init;
      dreg <= divisor;
      cnt  <= count;
    end else if (run) begin
      if (ge) begin
        rreg <= 48'(sh - {1'b0, dreg});
        nreg <= {nreg[62:0], 1'b1};
      end else begin
        rreg <= sh[47:0];
        nreg <= {nreg[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
    end
  end

endmodule

[rtl/core/bao_sqrt.sv]
module bao_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v, r, bitv;
  logic [4:0]  j;
  logic        run;
  logic [64:0] trial;

  assign bitv  = 64'd1 << {j, 1'b0};
  assign trial = {1'b0, r} + {1'b0, bitv};
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && j == 5'd0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      r <= 64'd0;
      j <= 5'd31;
    end else if (run) begin
      if ({1'b0, v} >= trial) begin
        v <= v - trial[63:0];
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      j <= j - 5'd1;
    end
  end

endmodule

[rtl/core/binomial_american_option_price.sv]
// American option pricer on a Cox-Ross-Rubinstein binomial tree.
// Input beats on s_*: tdata carries spot, strike, maturity, volatility and
// rate; tuser carries the put flag. One result beat per input on m_*: tdata
// is the root value (Q16.16, saturated), tuser the bad-input flag.
// tree_steps is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while idle (unchecked); zero counts as one step, above 1024 as 1024.
// s_tready is high only while idle; one option is priced at a time.
// Sequence, N = steps: setup (serial divides, square root and four
// exponentials on the shared unit), the power tables, the N+1 payoffs,
// then the N*(N+1)/2 interior nodes, each with five products on the
// multiplier plus one node-memory read.
// Reset returns the sequencer to idle, drops m_tvalid and sets tree_steps
// to 256. The node and power memories need no clearing.
// A finished result waits in the output register; a new beat is taken while
// it waits, but the next result holds until m_tready drains the first.
module binomial_american_option_price (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // spot_price, strike_price, time_to_expiry,
                                  // volatility, interest_rate
  input  logic         s_tuser,   // is_put
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // option_value
  output logic         m_tuser    // bad_input
);

  localparam int W  = bao_pkg::W;
  localparam int AW = bao_pkg::AW;

  bao_pkg::state_t state, state_next;
  logic pend, pend_next;
  logic m_valid_next;
  logic [10:0] tree_steps;

  logic [31:0] spot, strike, mat, vol, rmag;
  logic [31:0] spot_next, strike_next, mat_next, vol_next, rmag_next;
  logic rneg, rneg_next, put, put_next;
  logic [AW-1:0] nsteps, nsteps_next;
  logic [W-1:0] dt, dt_next, a, a_next, rm, rm_next;
  logic [31:0] sq, sq_next;
  logic [1:0] esel, esel_next;
  logic [15:0] k, k_next;
  logic [31:0] ff, ff_next;
  logic zf, zf_next;
  logic [3:0] nn, nn_next;
  logic [W-1:0] term, term_next, sum, sum_next;
  logic [W-1:0] up_factor, up_factor_next, down_factor, down_factor_next;
  logic [W-1:0] growth, growth_next, step_discount, step_discount_next;
  logic [W-1:0] up_probability, up_probability_next, omq;
  logic bad, bad_next;
  logic [W-1:0] pu, pu_next, pd, pd_next;
  logic [AW-1:0] i, i_next, t, t_next;
  logic trow, trow_next;
  logic [W-1:0] upv, upv_next, dnv, dnv_next, vhi, vhi_next, vlo, vlo_next;
  logic [W-1:0] s1, s1_next, ex, ex_next, m3, m3_next, mix, mix_next;
  logic [W-1:0] root_val, root_val_next;
  logic [31:0] out_val, out_val_next;
  logic out_bad, out_bad_next;

  logic mul_go, mul_done;
  logic [W-1:0] mul_a, mul_b, mul_res;
  logic div_go, div_done;
  logic [63:0] div_n, div_q;
  logic [47:0] div_d, div_r0;
  logic [6:0] div_cnt;
  logic sq_go, sq_done;
  logic [63:0] sq_v;
  logic [31:0] sq_root;

  logic up_we, dn_we, node_we;
  logic [AW-1:0] node_raddr, dn_raddr;
  logic [W-1:0] up_rd, dn_rd, node_rd, node_wdata;

  function automatic logic [W-1:0] payoff(input logic [W-1:0] s, input logic [31:0] kk,
                                          input logic p);
    logic [W-1:0] kw;
    kw = {16'b0, kk};
    if (p) begin
      return (kw > s) ? kw - s : '0;
    end
    return (s > kw) ? s - kw : '0;
  endfunction

  assign s_tready = (state == bao_pkg::ST_IDLE);
  assign omq      = bao_pkg::ONE - up_probability;
  assign m_tdata  = out_val;
  assign m_tuser  = out_bad;
  assign dn_raddr = t - i;
  assign node_raddr = (state == bao_pkg::ST_ROW) ? '0 : i + AW'(1);

  bao_mulq u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  bao_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_n), .divisor(div_d),
    .rem_init(div_r0), .count(div_cnt), .done(div_done), .quotient(div_q)
  );

  bao_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go), .value(sq_v), .done(sq_done), .root(sq_root)
  );

  bao_mem u_upm (
    .clk(clk), .we(up_we), .waddr(i), .wdata(pu), .raddr(i), .rdata(up_rd)
  );

  bao_mem u_dnm (
    .clk(clk), .we(dn_we), .waddr(i), .wdata(pd), .raddr(dn_raddr), .rdata(dn_rd)
  );

  bao_mem u_node (
    .clk(clk), .we(node_we), .waddr(i), .wdata(node_wdata), .raddr(node_raddr),
    .rdata(node_rd)
  );

  always_comb begin
    logic [63:0] shl;
    logic [16:0] shn;
    logic [W-1:0] ev, nv, em, pay, fw;
    logic [48:0] msum;
    logic [31:0] fr;
    logic adv, eneg, kinc;

    state_next = state;
    pend_next = pend;
    m_valid_next = m_tvalid && !m_tready;
    spot_next = spot; strike_next = strike; mat_next = mat; vol_next = vol;
    rmag_next = rmag; rneg_next = rneg; put_next = put; nsteps_next = nsteps;
    dt_next = dt; sq_next = sq; a_next = a; rm_next = rm; esel_next = esel;
    k_next = k; ff_next = ff; zf_next = zf; nn_next = nn;
    term_next = term; sum_next = sum;
    up_factor_next = up_factor; down_factor_next = down_factor;
    growth_next = growth; step_discount_next = step_discount;
    up_probability_next = up_probability; bad_next = bad;
    pu_next = pu; pd_next = pd; i_next = i; t_next = t; trow_next = trow;
    upv_next = upv; dnv_next = dnv; vhi_next = vhi; vlo_next = vlo;
    s1_next = s1; ex_next = ex; m3_next = m3; mix_next = mix;
    root_val_next = root_val; out_val_next = out_val; out_bad_next = out_bad;

    mul_go = 1'b0; mul_a = '0; mul_b = '0;
    div_go = 1'b0; div_n = '0; div_d = '0; div_r0 = '0; div_cnt = bao_pkg::DIV_BITS;
    sq_go = 1'b0; sq_v = {dt, 16'b0};
    up_we = 1'b0; dn_we = 1'b0; node_we = 1'b0; node_wdata = ex;
    adv = 1'b0; nv = ex;

    em   = esel[1] ? rm : a;
    eneg = (esel == 2'd1) || (esel == 2'd2 && rneg) || (esel == 2'd3 && !rneg);
    fw   = em - mul_res;
    kinc = fw >= {16'b0, bao_pkg::LN2};
    fr   = kinc ? 32'(fw - {16'b0, bao_pkg::LN2}) : fw[31:0];
    shl  = {16'b0, sum} << k[3:0];
    shn  = zf ? {1'b0, k} : {1'b0, k} + 17'd1;
    if (!eneg) begin
      if (k >= 16'd16 || shl[63:48] != 16'd0) ev = bao_pkg::MAX48;
      else ev = shl[47:0];
    end else begin
      if (shn >= 17'd40) ev = '0;
      else ev = sum >> shn[5:0];
    end
    pay  = payoff(mul_res, strike, put);
    msum = {1'b0, m3} + {1'b0, mul_res};

    case (state)
      bao_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          spot_next   = s_tdata[31:0];
          strike_next = s_tdata[63:32];
          mat_next    = s_tdata[95:64];
          vol_next    = s_tdata[127:96];
          rneg_next   = s_tdata[159];
          rmag_next   = s_tdata[159] ? 32'(33'h1_0000_0000 - {1'b0, s_tdata[159:128]})
                                     : s_tdata[159:128];
          put_next    = s_tuser;
          if (tree_steps == 11'd0) nsteps_next = AW'(1);
          else if (tree_steps > 11'(bao_pkg::MAX_STEPS)) nsteps_next = bao_pkg::STEPS_MAX;
          else nsteps_next = AW'(tree_steps);
          state_next  = bao_pkg::ST_DT;
        end
      end
      bao_pkg::ST_DT: begin
        div_n = {16'b0, mat, 16'b0};
        div_d = 48'(nsteps);
        if (!pend) begin
          div_go = 1'b1; pend_next = 1'b1;
        end else if (div_done) begin
          pend_next = 1'b0; dt_next = div_q[47:0]; state_next = bao_pkg::ST_SQ;
        end
      end
      bao_pkg::ST_SQ: begin
        if (!pend) begin
          sq_go = 1'b1; pend_next = 1'b1;
        end else if (sq_done) begin
          pend_next = 1'b0; sq_next = sq_root; state_next = bao_pkg::ST_A;
        end
      end
      bao_pkg::ST_A: begin
        mul_a = {8'b0, vol, 8'b0};
        mul_b = {16'b0, sq};
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; a_next = mul_res; state_next = bao_pkg::ST_R;
        end
      end
      bao_pkg::ST_R: begin
        mul_a = {4'b0, rmag, 12'b0};
        mul_b = {16'b0, dt[47:16]};
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; rm_next = mul_res; esel_next = 2'd0;
          state_next = bao_pkg::ST_EK;
        end
      end
      bao_pkg::ST_EK: begin
        mul_a = em;
        mul_b = bao_pkg::INV_LN2;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; k_next = mul_res[47:32]; state_next = bao_pkg::ST_EM;
        end
      end
      bao_pkg::ST_EM: begin
        mul_a = {k, 32'b0};
        mul_b = {16'b0, bao_pkg::LN2};
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0;
          k_next    = kinc ? k + 16'd1 : k;
          zf_next   = eneg && fr == 32'd0;
          ff_next   = eneg ? bao_pkg::LN2 - fr : fr;
          term_next = bao_pkg::ONE;
          sum_next  = bao_pkg::ONE;
          nn_next   = 4'd1;
          state_next = (eneg && fr == 32'd0) ? bao_pkg::ST_EFIN : bao_pkg::ST_ET;
        end
      end
      bao_pkg::ST_ET: begin
        mul_a = term;
        mul_b = {16'b0, ff};
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; s1_next = mul_res; state_next = bao_pkg::ST_EN;
        end
      end
      bao_pkg::ST_EN: begin
        div_n = {16'b0, s1};
        div_d = 48'(nn);
        if (!pend) begin
          div_go = 1'b1; pend_next = 1'b1;
        end else if (div_done) begin
          pend_next = 1'b0;
          term_next = div_q[47:0];
          sum_next  = sum + div_q[47:0];
          if (nn == bao_pkg::EXP_TERMS) begin
            state_next = bao_pkg::ST_EFIN;
          end else begin
            nn_next = nn + 4'd1; state_next = bao_pkg::ST_ET;
          end
        end
      end
      bao_pkg::ST_EFIN: begin
        case (esel)
          2'd0:    up_factor_next = ev;
          2'd1:    down_factor_next = ev;
          2'd2:    growth_next = ev;
          default: step_discount_next = ev;
        endcase
        if (esel == 2'd3) begin
          state_next = bao_pkg::ST_Q;
        end else begin
          esel_next = esel + 2'd1; state_next = bao_pkg::ST_EK;
        end
      end
      bao_pkg::ST_Q: begin
        div_n   = '0;
        div_d   = up_factor - down_factor;
        div_r0  = growth - down_factor;
        div_cnt = bao_pkg::Q_BITS;
        pu_next = bao_pkg::ONE;
        pd_next = bao_pkg::ONE;
        i_next  = '0;
        if (!pend) begin
          if (up_factor <= down_factor || growth < down_factor) begin
            up_probability_next = '0; bad_next = 1'b1; state_next = bao_pkg::ST_PWR;
          end else if (growth > up_factor) begin
            up_probability_next = bao_pkg::ONE; bad_next = 1'b1;
            state_next = bao_pkg::ST_PWR;
          end else if (growth - down_factor >= up_factor - down_factor) begin
            up_probability_next = bao_pkg::ONE; bad_next = 1'b0;
            state_next = bao_pkg::ST_PWR;
          end else begin
            div_go = 1'b1; pend_next = 1'b1;
          end
        end else if (div_done) begin
          pend_next = 1'b0;
          up_probability_next = {16'b0, div_q[31:0]};
          bad_next = 1'b0;
          state_next = bao_pkg::ST_PWR;
        end
      end
      bao_pkg::ST_PWR: begin
        up_we = 1'b1;
        dn_we = 1'b1;
        if (i == nsteps) begin
          trow_next = 1'b1; t_next = nsteps; i_next = '0; state_next = bao_pkg::ST_NRD;
        end else begin
          state_next = bao_pkg::ST_PMU;
        end
      end
      bao_pkg::ST_PMU: begin
        mul_a = pu;
        mul_b = up_factor;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; pu_next = mul_res; state_next = bao_pkg::ST_PMD;
        end
      end
      bao_pkg::ST_PMD: begin
        mul_a = pd;
        mul_b = down_factor;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; pd_next = mul_res; i_next = i + AW'(1);
          state_next = bao_pkg::ST_PWR;
        end
      end
      bao_pkg::ST_ROW: begin
        if (!pend) begin
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0; vlo_next = node_rd; state_next = bao_pkg::ST_NRD;
        end
      end
      bao_pkg::ST_NRD: begin
        if (!pend) begin
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0; upv_next = up_rd; dnv_next = dn_rd; vhi_next = node_rd;
          state_next = bao_pkg::ST_NM1;
        end
      end
      bao_pkg::ST_NM1: begin
        mul_a = {16'b0, spot};
        mul_b = upv;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; s1_next = mul_res; state_next = bao_pkg::ST_NM2;
        end
      end
      bao_pkg::ST_NM2: begin
        mul_a = s1;
        mul_b = dnv;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0;
          ex_next = pay;
          if (trow) begin
            node_we = 1'b1; node_wdata = pay; nv = pay; adv = 1'b1;
          end else begin
            state_next = bao_pkg::ST_NM3;
          end
        end
      end
      bao_pkg::ST_NM3: begin
        mul_a = vhi;
        mul_b = up_probability;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0; m3_next = mul_res; state_next = bao_pkg::ST_NM4;
        end
      end
      bao_pkg::ST_NM4: begin
        mul_a = vlo;
        mul_b = omq;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0;
          mix_next = msum[48] ? bao_pkg::MAX48 : msum[47:0];
          state_next = bao_pkg::ST_NM5;
        end
      end
      bao_pkg::ST_NM5: begin
        mul_a = mix;
        mul_b = step_discount;
        if (!pend) begin
          mul_go = 1'b1; pend_next = 1'b1;
        end else if (mul_done) begin
          pend_next = 1'b0;
          nv = (ex > mul_res) ? ex : mul_res;
          node_we = 1'b1; node_wdata = nv; adv = 1'b1;
        end
      end
      bao_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_valid_next = 1'b1;
          out_val_next = (root_val[47:32] != 16'd0) ? 32'hFFFF_FFFF : root_val[31:0];
          out_bad_next = bad;
          state_next   = bao_pkg::ST_IDLE;
        end
      end
      default: state_next = bao_pkg::ST_IDLE;
    endcase

    if (adv) begin
      if (i == t) begin
        i_next = '0;
        if (trow) begin
          trow_next = 1'b0; t_next = nsteps - AW'(1); state_next = bao_pkg::ST_ROW;
        end else if (t == '0) begin
          root_val_next = nv; state_next = bao_pkg::ST_DONE;
        end else begin
          t_next = t - AW'(1); state_next = bao_pkg::ST_ROW;
        end
      end else begin
        i_next = i + AW'(1); vlo_next = vhi; state_next = bao_pkg::ST_NRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bao_pkg::ST_IDLE;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
      tree_steps <= bao_pkg::STEPS_RESET;
    end else begin
      state    <= state_next;
      pend     <= pend_next;
      m_tvalid <= m_valid_next;
      if (cfg_wr_en) begin
        tree_steps <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    spot <= spot_next; strike <= strike_next; mat <= mat_next; vol <= vol_next;
    rmag <= rmag_next; rneg <= rneg_next; put <= put_next; nsteps <= nsteps_next;
    dt <= dt_next; sq <= sq_next; a <= a_next; rm <= rm_next; esel <= esel_next;
    k <= k_next; ff <= ff_next; zf <= zf_next; nn <= nn_next;
    term <= term_next; sum <= sum_next;
    up_factor <= up_factor_next; down_factor <= down_factor_next;
    growth <= growth_next; step_discount <= step_discount_next;
    up_probability <= up_probability_next; bad <= bad_next;
    pu <= pu_next; pd <= pd_next; i <= i_next; t <= t_next; trow <= trow_next;
    upv <= upv_next; dnv <= dnv_next; vhi <= vhi_next; vlo <= vlo_next;
    s1 <= s1_next; ex <= ex_next; m3 <= m3_next; mix <= mix_next;
    root_val <= root_val_next; out_val <= out_val_next; out_bad <= out_bad_next;
  end

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !pend |-> !(mul_done || div_done || sq_done))
    else $error("unit result without a pending request");

  a_node_index: assert property (@(posedge clk) disable iff (rst)
    state == bao_pkg::ST_NRD |-> i <= t)
    else $error("node index beyond row");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == bao_pkg::ST_DONE)
    else $error("result beat not from finish");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    state == bao_pkg::ST_PWR |-> up_probability <= bao_pkg::ONE)
    else $error("probability above one");

endmodule

[test/tb_binomial_american_option_price.sv]
module tb_binomial_american_option_price;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [31:0] rate;
    logic [31:0] vol;
    logic [31:0] mat;
    logic [31:0] strike;
    logic [31:0] spot;
  } option_t;

  class option_board;
    localparam u64_t MAXV = 64'h0000_FFFF_FFFF_FFFF;
    localparam u64_t ONEV = 64'h0000_0001_0000_0000;
    localparam u64_t LN2V = 64'd2977044472;

    logic [10:0] steps_reg;
    logic [32:0] pending_q[$];
    int          failures;
    u64_t        up_pow[bao_pkg::MAX_STEPS+1];
    u64_t        dn_pow[bao_pkg::MAX_STEPS+1];
    u64_t        node[bao_pkg::MAX_STEPS+1];

    function new();
      steps_reg = bao_pkg::STEPS_RESET;
      failures  = 0;
    endfunction

    function u64_t mulq(u64_t a, u64_t b);
      u64_t ah, al, bh, bl, hh, mid, t, res;
      ah = (a >> 24) & 64'hFFFFFF;
      al = a & 64'hFFFFFF;
      bh = (b >> 24) & 64'hFFFFFF;
      bl = b & 64'hFFFFFF;
      hh = ah * bh;
      if (hh >= ONEV) return MAXV;
      mid = ah * bl + al * bh;
      t = ((al * bl) >> 24) + mid;
      res = (hh << 16) + (t >> 8);
      return (res > MAXV) ? MAXV : res;
    endfunction

    function u64_t isqrt(u64_t v);
      u64_t r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      return r;
    endfunction

    function u64_t exp_frac(u64_t f);
      u64_t term, sum;
      term = ONEV;
      sum = ONEV;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * f) >> 32) / n;
        sum += term;
      end
      return sum;
    endfunction

    function u64_t exp_fix(bit neg, u64_t m);
      u64_t k, f, e, sh;
      k = m / LN2V;
      f = m - k * LN2V;
      if (!neg) begin
        if (k >= 16) return MAXV;
        e = exp_frac(f) << k;
        return (e > MAXV) ? MAXV : e;
      end
      if (f == 0) begin
        e = ONEV;
        sh = k;
      end else begin
        e = exp_frac(LN2V - f);
        sh = k + 1;
      end
      return (sh >= 40) ? 0 : (e >> sh);
    endfunction

    function u64_t payoff(u64_t s, u64_t k, bit put);
      if (put) return (k > s) ? k - s : 0;
      return (s > k) ? s - k : 0;
    endfunction

    function void note_option(option_t o, bit put);
      u64_t n, dt, sq, a, rmag, g, q, up, dn, disc, rem, den, s, ex, mix, cont;
      bit rneg, bad;
      n = steps_reg;
      if (n == 0) n = 1;
      if (n > bao_pkg::MAX_STEPS) n = bao_pkg::MAX_STEPS;
      bad = 0;
      dt = (u64_t'(o.mat) << 16) / n;
      sq = isqrt(dt << 16);
      a = (u64_t'(o.vol) * sq) >> 24;
      rneg = o.rate[31];
      rmag = rneg ? (ONEV - u64_t'(o.rate)) : u64_t'(o.rate);
      rmag = (rmag * (dt >> 16)) >> 20;
      up = exp_fix(0, a);
      dn = exp_fix(1, a);
      g = exp_fix(rneg, rmag);
      disc = exp_fix(!rneg, rmag);
      if (up <= dn || g < dn) begin
        q = 0;
        bad = 1;
      end else if (g > up) begin
        q = ONEV;
        bad = 1;
      end else begin
        rem = g - dn;
        den = up - dn;
        q = 0;
        if (rem >= den) begin
          q = ONEV;
        end else begin
          for (int b = 0; b < 32; b++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
              rem -= den;
              q |= 1;
            end
          end
        end
      end
      up_pow[0] = ONEV;
      dn_pow[0] = ONEV;
      for (int i = 1; i <= n; i++) begin
        up_pow[i] = mulq(up_pow[i-1], up);
        dn_pow[i] = mulq(dn_pow[i-1], dn);
      end
      for (int i = 0; i <= n; i++) begin
        s = mulq(mulq(o.spot, up_pow[i]), dn_pow[n-i]);
        node[i] = payoff(s, o.strike, put);
      end
      for (int t = n - 1; t >= 0; t--) begin
        for (int i = 0; i <= t; i++) begin
          s = mulq(mulq(o.spot, up_pow[i]), dn_pow[t-i]);
          ex = payoff(s, o.strike, put);
          mix = mulq(node[i+1], q) + mulq(node[i], ONEV - q);
          if (mix > MAXV) mix = MAXV;
          cont = mulq(mix, disc);
          node[i] = (ex > cont) ? ex : cont;
        end
      end
      s = (node[0] > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : node[0];
      pending_q.push_back({bad, s[31:0]});
    endfunction

    function void check_result(logic [31:0] value, logic flag);
      logic [32:0] exp_r;
      if (pending_q.size() == 0) begin
        $error("result beat with no pending option: option_value %h bad_input %b",
               value, flag);
        failures++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (value !== exp_r[31:0]) begin
        $error("option_value expected %h actual %h", exp_r[31:0], value);
        failures++;
      end
      if (flag !== exp_r[32]) begin
        $error("bad_input expected %b actual %b", exp_r[32], flag);
        failures++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  logic [10:0]  cfg_wr_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic         m_tuser;

  option_board board;
  bit          no_idle;

  binomial_american_option_price dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_option(s_tdata, s_tuser);
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 31);
  end

  task automatic send_option(option_t o, bit put);
    while (!no_idle && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= o;
    s_tuser  <= put;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic set_steps(logic [10:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.steps_reg = v;
  endtask

  function automatic option_t plain_option(logic [31:0] spot, logic [31:0] strike,
                                           logic [31:0] mat, logic [31:0] vol,
                                           logic [31:0] rate);
    option_t o;
    o.spot = spot;
    o.strike = strike;
    o.mat = mat;
    o.vol = vol;
    o.rate = rate;
    return o;
  endfunction

  function automatic option_t random_option();
    option_t o;
    if ($urandom_range(99) < 25) begin
      o = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      o.spot   = $urandom_range(32'd300 << 16, 32'd10 << 16);
      o.strike = o.spot + $urandom_range(32'd40 << 16) - (32'd20 << 16);
      o.mat    = $urandom_range(32'd3 << 24, 32'd1 << 20);
      o.vol    = $urandom_range(32'd1 << 28, 32'd1 << 24);
      o.rate   = $urandom_range(32'd1 << 26) - (32'd1 << 24);
    end
    return o;
  endfunction

  initial begin
    board = new();
    no_idle = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    m_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_option(plain_option(32'd100 << 16, 32'd100 << 16, 32'd1 << 24,
                             32'd1 << 26, 32'd1 << 23), 1'b1);

    set_steps(11'd0);
    send_option(plain_option('0, '0, '0, '0, '0), 1'b0);
    send_option(plain_option('1, '1, '1, '1, '1), 1'b1);
    send_option(plain_option('1, '0, '1, '1, 32'h7FFF_FFFF), 1'b0);
    send_option(plain_option(32'd50 << 16, 32'd60 << 16, 32'd1 << 24, '0,
                             32'd1 << 24), 1'b1);
    send_option(plain_option(32'd50 << 16, 32'd40 << 16, '0, 32'd1 << 27,
                             32'd1 << 24), 1'b0);
    send_option(plain_option(32'd50 << 16, 32'd40 << 16, 32'd1 << 24, 32'd1 << 12,
                             32'h8000_0000), 1'b1);
    send_option(plain_option(32'd50 << 16, 32'd40 << 16, 32'd1 << 24, 32'd1 << 16,
                             32'h7FFF_FFFF), 1'b0);
    send_option(plain_option(32'd80 << 16, 32'd100 << 16, 32'd2 << 24, 32'd1 << 27,
                             32'hFF00_0000), 1'b1);

    set_steps(11'd2047);
    send_option(plain_option(32'd100 << 16, 32'd95 << 16, 32'd1 << 24,
                             32'd3 << 26, 32'd1 << 23), 1'b1);

    set_steps(11'd1024);
    set_steps(11'd3);
    send_option(plain_option(32'd100 << 16, 32'd110 << 16, 32'd1 << 24,
                             32'd1 << 27, 32'h8000_0000), 1'b0);
    send_option(plain_option(32'd100 << 16, 32'd90 << 16, 32'd1 << 23,
                             32'd1 << 27, 32'd1 << 22), 1'b1);

    for (int k = 0; k < 100; k++) begin
      if (k % 12 == 0) set_steps(11'($urandom_range(8, 1)));
      no_idle = (k >= 40 && k < 60);
      send_option(random_option(), 1'($urandom));
    end
    no_idle = 0;
    s_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.failures == 0) begin
      $display("binomial_american_option_price: match");
    end else begin
      $display("binomial_american_option_price: mismatch");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("binomial_american_option_price: mismatch");
    $finish;
  end

endmodule
